// File: hw/rtl/u8ls_pkg.sv
// Shared types and constants for the UTF-8 validating line splitter.
// Used by the front end, the command queue, the back end and the checker.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package u8ls_pkg;

  localparam int unsigned LINE_MAX_DEF = 64;
  // Position fields in a command are sized for the widest LINE_MAX (128)
  localparam int unsigned POS_W        = 7;
  localparam int unsigned CMD_DEPTH    = 2;
  localparam int unsigned LNUM_W       = 16;

  localparam logic [1:0] MODE_DATA  = 2'd0;
  localparam logic [1:0] MODE_END   = 2'd1;
  localparam logic [1:0] MODE_START = 2'd2;

  localparam logic [1:0] KIND_CHAR = 2'd0;
  localparam logic [1:0] KIND_DONE = 2'd1;
  localparam logic [1:0] KIND_ERR  = 2'd2;

  localparam logic [1:0] ERR_UTF8  = 2'd0;
  localparam logic [1:0] ERR_LONG  = 2'd1;
  localparam logic [1:0] ERR_TRUNC = 2'd2;

  localparam logic [7:0] CHAR_NUL = 8'h00;
  localparam logic [7:0] CHAR_TAB = 8'h09;
  localparam logic [7:0] CHAR_LF  = 8'h0A;
  localparam logic [7:0] CHAR_CR  = 8'h0D;
  localparam logic [7:0] CHAR_SP  = 8'h20;

  typedef enum logic [1:0] {
    CMD_LINE,
    CMD_LINE_DONE,
    CMD_DONE,
    CMD_ERR
  } cmd_kind_e;

  // One queued job for the back end
  typedef struct packed {
    cmd_kind_e         kind;
    logic              bank;
    logic [POS_W-1:0]  first;
    logic [POS_W-1:0]  stop;
    logic [1:0]        err;
    logic [LNUM_W-1:0] lnum;
  } cmd_t;

  // Back end hands a line bank back to the front end
  typedef struct packed {
    logic valid;
    logic bank;
  } rel_t;

endpackage

`default_nettype wire

// File: hw/rtl/u8ls_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module u8ls_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 128,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/u8ls_fifo.sv
// Short command queue between front end and back end.
// Depends on u8ls_pkg.
`timescale 1ns / 1ps
`default_nettype none

module u8ls_fifo (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire u8ls_pkg::cmd_t data_i,
  output logic                full_o,
  output logic                valid_o,
  input  wire logic           pop_i,
  output u8ls_pkg::cmd_t      data_o
);

  localparam int unsigned PTR_W = (u8ls_pkg::CMD_DEPTH > 1) ? $clog2(u8ls_pkg::CMD_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(u8ls_pkg::CMD_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(u8ls_pkg::CMD_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(u8ls_pkg::CMD_DEPTH);

  u8ls_pkg::cmd_t   mem_q [u8ls_pkg::CMD_DEPTH];
  logic [PTR_W-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_FULL);
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PTR_LAST) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PTR_LAST) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/u8ls_front.sv
// Front end: takes input words, checks UTF-8, stores line bytes into a
// ping-pong line buffer and queues line/done/error jobs. Depends on u8ls_pkg.
`timescale 1ns / 1ps
`default_nettype none

module u8ls_front #(
  parameter int unsigned LINE_MAX = u8ls_pkg::LINE_MAX_DEF,
  localparam int unsigned LEN_W   = $clog2(LINE_MAX)
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire logic [1:0]     mode_i,
  input  wire logic [7:0]     data_byte_i,
  output u8ls_pkg::cmd_t      cmd_o,
  output logic                cmd_push_o,
  input  wire logic           cmd_full_i,
  input  wire u8ls_pkg::rel_t rel_i,
  output logic                ram_we_o,
  output logic [LEN_W:0]      ram_waddr_o,
  output logic [7:0]          ram_wdata_o
);

  localparam logic [LEN_W-1:0] LEN_FULL = LEN_W'(LINE_MAX - 1);

  logic [20:0]       code_q, code_d, code_n, code_sh;
  logic [16:0]       min_q, min_d, min_n;
  logic [1:0]        pend_q, pend_d, pend_n;
  logic              skip_q, skip_d;
  logic [LEN_W-1:0]  len_q, len_d, first_q, first_d, stop_q, stop_d;
  logic              nul_q, nul_d, nb_q, nb_d;
  logic [15:0]       cnt_q, cnt_d;
  logic              abort_q, abort_d;
  logic              wbank_q, wbank_d;
  logic [1:0]        busy_q, busy_d;
  logic              accept, utf_bad, is_eol, is_blank;
  logic [7:0]        b;

  assign b          = data_byte_i;
  assign in_ready_o = !cmd_full_i && !busy_q[wbank_q];
  assign accept     = in_valid_i && in_ready_o;
  assign is_eol     = (b == u8ls_pkg::CHAR_CR) || (b == u8ls_pkg::CHAR_LF);
  assign is_blank   = (b == u8ls_pkg::CHAR_SP) || (b == u8ls_pkg::CHAR_TAB);
  assign code_sh    = {code_q[14:0], b[5:0]};

  // UTF-8 decoder step
  always_comb begin
    code_n  = code_q;
    min_n   = min_q;
    pend_n  = pend_q;
    utf_bad = 1'b0;
    if (pend_q == 2'd0) begin
      priority if (b < 8'h80) begin
        utf_bad = 1'b0;
      end else if (b >= 8'hC2 && b <= 8'hDF) begin
        code_n = {16'd0, b[4:0]};
        min_n  = 17'h00080;
        pend_n = 2'd1;
      end else if (b >= 8'hE0 && b <= 8'hEF) begin
        code_n = {17'd0, b[3:0]};
        min_n  = 17'h00800;
        pend_n = 2'd2;
      end else if (b >= 8'hF0 && b <= 8'hF4) begin
        code_n = {18'd0, b[2:0]};
        min_n  = 17'h10000;
        pend_n = 2'd3;
      end else begin
        utf_bad = 1'b1;
      end
    end else if (b[7:6] != 2'b10) begin
      utf_bad = 1'b1;
    end else begin
      code_n = code_sh;
      pend_n = pend_q - 2'd1;
      if (pend_n == 2'd0 &&
          (code_sh < {4'd0, min_q} ||
           (code_sh >= 21'h00D800 && code_sh <= 21'h00DFFF) ||
           code_sh > 21'h10FFFF)) begin
        utf_bad = 1'b1;
      end
    end
  end

  always_comb begin
    code_d  = code_q;
    min_d   = min_q;
    pend_d  = pend_q;
    skip_d  = skip_q;
    len_d   = len_q;
    first_d = first_q;
    stop_d  = stop_q;
    nul_d   = nul_q;
    nb_d    = nb_q;
    cnt_d   = cnt_q;
    abort_d = abort_q;
    wbank_d = wbank_q;
    busy_d  = busy_q;

    cmd_push_o  = 1'b0;
    cmd_o.kind  = u8ls_pkg::CMD_DONE;
    cmd_o.bank  = wbank_q;
    cmd_o.first = u8ls_pkg::POS_W'(first_q);
    cmd_o.stop  = u8ls_pkg::POS_W'(stop_q);
    cmd_o.err   = u8ls_pkg::ERR_UTF8;
    cmd_o.lnum  = cnt_q;
    ram_we_o    = 1'b0;
    ram_waddr_o = {wbank_q, len_q};
    ram_wdata_o = b;

    if (rel_i.valid) begin
      busy_d[rel_i.bank] = 1'b0;
    end

    if (accept) begin
      if (mode_i == u8ls_pkg::MODE_START) begin
        code_d  = '0;
        min_d   = '0;
        pend_d  = '0;
        skip_d  = 1'b0;
        len_d   = '0;
        first_d = '0;
        stop_d  = '0;
        nul_d   = 1'b0;
        nb_d    = 1'b0;
        cnt_d   = 16'd1;
        abort_d = 1'b0;
      end else if (!abort_q && mode_i == u8ls_pkg::MODE_END) begin
        abort_d    = 1'b1;
        cmd_push_o = 1'b1;
        len_d      = '0;
        first_d    = '0;
        stop_d     = '0;
        nul_d      = 1'b0;
        nb_d       = 1'b0;
        if (pend_q != 2'd0) begin
          cmd_o.kind = u8ls_pkg::CMD_ERR;
          cmd_o.err  = u8ls_pkg::ERR_TRUNC;
        end else if (nb_q) begin
          cmd_o.kind      = u8ls_pkg::CMD_LINE_DONE;
          busy_d[wbank_q] = 1'b1;
          wbank_d         = !wbank_q;
        end
      end else if (!abort_q && mode_i == u8ls_pkg::MODE_DATA) begin
        code_d = code_n;
        min_d  = min_n;
        pend_d = pend_n;
        if (utf_bad) begin
          abort_d    = 1'b1;
          cmd_push_o = 1'b1;
          cmd_o.kind = u8ls_pkg::CMD_ERR;
          cmd_o.err  = u8ls_pkg::ERR_UTF8;
        end else if (is_eol) begin
          if (b == u8ls_pkg::CHAR_LF && skip_q) begin
            // second half of CR LF
            skip_d = 1'b0;
          end else begin
            skip_d = (b == u8ls_pkg::CHAR_CR);
            if (nb_q) begin
              cmd_push_o      = 1'b1;
              cmd_o.kind      = u8ls_pkg::CMD_LINE;
              busy_d[wbank_q] = 1'b1;
              wbank_d         = !wbank_q;
            end
            len_d   = '0;
            first_d = '0;
            stop_d  = '0;
            nul_d   = 1'b0;
            nb_d    = 1'b0;
            if (cnt_q != 16'hFFFF) begin
              cnt_d = cnt_q + 16'd1;
            end
          end
        end else begin
          skip_d = 1'b0;
          if (len_q >= LEN_FULL) begin
            abort_d    = 1'b1;
            cmd_push_o = 1'b1;
            cmd_o.kind = u8ls_pkg::CMD_ERR;
            cmd_o.err  = u8ls_pkg::ERR_LONG;
          end else begin
            ram_we_o = 1'b1;
            len_d    = len_q + 1'b1;
            // trim bounds: everything from the first NUL on is dropped
            if (!nul_q) begin
              if (b == u8ls_pkg::CHAR_NUL) begin
                nul_d = 1'b1;
              end else if (!is_blank) begin
                if (!nb_q) begin
                  first_d = len_q;
                end
                stop_d = len_q + 1'b1;
                nb_d   = 1'b1;
              end
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      code_q  <= '0;
      min_q   <= '0;
      pend_q  <= '0;
      skip_q  <= 1'b0;
      len_q   <= '0;
      first_q <= '0;
      stop_q  <= '0;
      nul_q   <= 1'b0;
      nb_q    <= 1'b0;
      cnt_q   <= 16'd1;
      abort_q <= 1'b0;
      wbank_q <= 1'b0;
      busy_q  <= '0;
    end else begin
      code_q  <= code_d;
      min_q   <= min_d;
      pend_q  <= pend_d;
      skip_q  <= skip_d;
      len_q   <= len_d;
      first_q <= first_d;
      stop_q  <= stop_d;
      nul_q   <= nul_d;
      nb_q    <= nb_d;
      cnt_q   <= cnt_d;
      abort_q <= abort_d;
      wbank_q <= wbank_d;
      busy_q  <= busy_d;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/u8ls_back.sv
// Back end: pops queued jobs, reads trimmed lines out of the line buffer
// and drives the result register. Depends on u8ls_pkg.
`timescale 1ns / 1ps
`default_nettype none

module u8ls_back #(
  parameter int unsigned LINE_MAX = u8ls_pkg::LINE_MAX_DEF,
  localparam int unsigned LEN_W   = $clog2(LINE_MAX)
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           cmd_valid_i,
  input  wire u8ls_pkg::cmd_t cmd_i,
  output logic                pop_o,
  output u8ls_pkg::rel_t      rel_o,
  output logic                ram_re_o,
  output logic [LEN_W:0]      ram_raddr_o,
  input  wire logic [7:0]     ram_rdata_i,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output logic [1:0]          kind_o,
  output logic [7:0]          char_out_o,
  output logic                last_of_line_o,
  output logic [1:0]          error_code_o,
  output logic [15:0]         line_number_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHAR,
    S_DONE
  } state_e;

  state_e           state_q, state_d;
  u8ls_pkg::cmd_t   cur_q, cur_d;
  logic [LEN_W-1:0] idx_q, idx_d, idx_nx;
  logic             out_valid_q, out_valid_d, out_free, load, is_last;
  logic [1:0]       kind_q, kind_d, err_q, err_d;
  logic [7:0]       char_q, char_d;
  logic             last_q, last_d;
  logic [15:0]      lnum_q, lnum_d;

  assign out_free = !out_valid_q || out_ready_i;
  assign idx_nx   = idx_q + 1'b1;
  assign is_last  = (idx_nx == cur_q.stop[LEN_W-1:0]);

  always_comb begin
    state_d     = state_q;
    cur_d       = cur_q;
    idx_d       = idx_q;
    load        = 1'b0;
    kind_d      = kind_q;
    char_d      = char_q;
    last_d      = last_q;
    err_d       = err_q;
    lnum_d      = lnum_q;
    pop_o       = 1'b0;
    rel_o.valid = 1'b0;
    rel_o.bank  = cur_q.bank;
    ram_re_o    = 1'b0;
    ram_raddr_o = {cmd_i.bank, cmd_i.first[LEN_W-1:0]};

    unique case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          unique case (cmd_i.kind)
            u8ls_pkg::CMD_LINE, u8ls_pkg::CMD_LINE_DONE: begin
              // start the first read; data is ready in S_CHAR
              pop_o    = 1'b1;
              cur_d    = cmd_i;
              idx_d    = cmd_i.first[LEN_W-1:0];
              ram_re_o = 1'b1;
              state_d  = S_CHAR;
            end
            u8ls_pkg::CMD_DONE, u8ls_pkg::CMD_ERR: begin
              if (out_free) begin
                pop_o  = 1'b1;
                load   = 1'b1;
                char_d = 8'd0;
                last_d = 1'b0;
                lnum_d = cmd_i.lnum;
                if (cmd_i.kind == u8ls_pkg::CMD_ERR) begin
                  kind_d = u8ls_pkg::KIND_ERR;
                  err_d  = cmd_i.err;
                end else begin
                  kind_d = u8ls_pkg::KIND_DONE;
                  err_d  = u8ls_pkg::ERR_UTF8;
                end
              end
            end
            default: begin
              pop_o = 1'b0;
            end
          endcase
        end
      end
      S_CHAR: begin
        ram_raddr_o = {cur_q.bank, idx_nx};
        if (out_free) begin
          load   = 1'b1;
          kind_d = u8ls_pkg::KIND_CHAR;
          char_d = ram_rdata_i;
          last_d = is_last;
          err_d  = u8ls_pkg::ERR_UTF8;
          lnum_d = cur_q.lnum;
          if (is_last) begin
            rel_o.valid = 1'b1;
            state_d     = (cur_q.kind == u8ls_pkg::CMD_LINE_DONE) ? S_DONE : S_IDLE;
          end else begin
            idx_d    = idx_nx;
            ram_re_o = 1'b1;
          end
        end
      end
      S_DONE: begin
        if (out_free) begin
          load    = 1'b1;
          kind_d  = u8ls_pkg::KIND_DONE;
          char_d  = 8'd0;
          last_d  = 1'b0;
          err_d   = u8ls_pkg::ERR_UTF8;
          lnum_d  = cur_q.lnum;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    out_valid_d = load ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      cur_q       <= '0;
      idx_q       <= '0;
      kind_q      <= '0;
      char_q      <= '0;
      last_q      <= 1'b0;
      err_q       <= '0;
      lnum_q      <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      cur_q       <= cur_d;
      idx_q       <= idx_d;
      kind_q      <= kind_d;
      char_q      <= char_d;
      last_q      <= last_d;
      err_q       <= err_d;
      lnum_q      <= lnum_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign kind_o         = kind_q;
  assign char_out_o     = char_q;
  assign last_of_line_o = last_q;
  assign error_code_o   = err_q;
  assign line_number_o  = lnum_q;

endmodule

`default_nettype wire

// File: hw/rtl/utf8_validating_line_splitter.sv
// Top level of the UTF-8 validating line splitter: front end, command queue,
// back end and the ping-pong line buffer RAM. Depends on u8ls_pkg and submodules.
//
//   channel | signals                                    | direction
//   --------+--------------------------------------------+----------
//   in      | in_valid_i/in_ready_o, mode_i, data_byte_i | to block
//   out     | out_valid_o/out_ready_i, kind_o, char_out_o,| from block
//           | last_of_line_o, error_code_o, line_number_o|
//
// Input words are taken one per cycle. A line end hands the line to the back
// end through a 2-entry job queue; the front then fills the other line bank.
// The front stalls only when the queue is full or both banks await readout.
// The back end emits one character per cycle while output is ready, after
// a registered RAM read per line; output stalls hold the result register.
// Reset clears all control state; the line RAM needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module utf8_validating_line_splitter #(
  parameter int unsigned LINE_MAX = u8ls_pkg::LINE_MAX_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  mode_i,
  input  wire logic [7:0]  data_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [1:0]       kind_o,
  output logic [7:0]       char_out_o,
  output logic             last_of_line_o,
  output logic [1:0]       error_code_o,
  output logic [15:0]      line_number_o
);

  localparam int unsigned LEN_W = $clog2(LINE_MAX);

  u8ls_pkg::cmd_t push_cmd, head_cmd;
  u8ls_pkg::rel_t rel;
  logic           push, full, head_valid, pop;
  logic           ram_we, ram_re;
  logic [LEN_W:0] ram_waddr, ram_raddr;
  logic [7:0]     ram_wdata, ram_rdata;

  u8ls_front #(
    .LINE_MAX (LINE_MAX)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .mode_i      (mode_i),
    .data_byte_i (data_byte_i),
    .cmd_o       (push_cmd),
    .cmd_push_o  (push),
    .cmd_full_i  (full),
    .rel_i       (rel),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata)
  );

  u8ls_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_cmd),
    .full_o  (full),
    .valid_o (head_valid),
    .pop_i   (pop),
    .data_o  (head_cmd)
  );

  u8ls_ram #(
    .WIDTH (8),
    .DEPTH (2 ** (LEN_W + 1))
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  u8ls_back #(
    .LINE_MAX (LINE_MAX)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_valid_i    (head_valid),
    .cmd_i          (head_cmd),
    .pop_o          (pop),
    .rel_o          (rel),
    .ram_re_o       (ram_re),
    .ram_raddr_o    (ram_raddr),
    .ram_rdata_i    (ram_rdata),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .kind_o         (kind_o),
    .char_out_o     (char_out_o),
    .last_of_line_o (last_of_line_o),
    .error_code_o   (error_code_o),
    .line_number_o  (line_number_o)
  );

endmodule

`default_nettype wire

// File: hw/rtl/u8ls_checker.sv
// Port-level checks for the UTF-8 validating line splitter, bound to the top.
// Depends on u8ls_pkg.
`timescale 1ns / 1ps
`default_nettype none

module u8ls_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_o,
  input wire logic [1:0]  mode_i,
  input wire logic [7:0]  data_byte_i,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [1:0]  kind_o,
  input wire logic [7:0]  char_out_o,
  input wire logic        last_of_line_o,
  input wire logic [1:0]  error_code_o,
  input wire logic [15:0] line_number_o
);

  // a waiting input word holds
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(mode_i) && $stable(data_byte_i))
    else $error("input word changed while waiting");

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(kind_o) &&
    $stable(char_out_o) && $stable(last_of_line_o) && $stable(line_number_o))
    else $error("result changed while stalled");

  a_lnum_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> line_number_o != 16'd0)
    else $error("line number zero");

  a_nonchar_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o != u8ls_pkg::KIND_CHAR |-> !last_of_line_o && char_out_o == 8'd0)
    else $error("status word carries character fields");

  a_errcode_only_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o != u8ls_pkg::KIND_ERR |-> error_code_o == u8ls_pkg::ERR_UTF8)
    else $error("error code on a non-error word");

endmodule

bind utf8_validating_line_splitter u8ls_checker u_chk (.*);

`default_nettype wire

// File: dv/tb_utf8_validating_line_splitter.sv
// Testbench for utf8_validating_line_splitter: directed table, then random scripts.
// Expected words come from a behavioral splitter in this file or typed table rows.
// Depends on u8ls_pkg and the RTL top level only.
`timescale 1ns / 1ps

module tb_utf8_validating_line_splitter;
  import u8ls_pkg::*;

  localparam int unsigned LINE_MAX = LINE_MAX_DEF;
  localparam int HALF_PERIOD  = 10;
  localparam int RESET_CYCLES = 10;
  localparam int ITEM_TARGET  = 260;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 50;
  localparam int MAX_REPORTS  = 10;

  localparam logic [1:0] MODE_NONE = 2'd3;  // ignored by the block
  localparam logic [1:0] ERR_NONE  = 2'd0;  // error field on non-error words

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  ch;
    logic        last;
    logic [1:0]  err;
    logic [15:0] lnum;
  } line_word_t;

  typedef enum logic [1:0] {
    CHK_PRED,   // expectation from the predictor
    CHK_QUIET,  // no word may come out
    CHK_TYPED   // exactly the word given in the row
  } row_chk_e;

  typedef struct packed {
    logic [1:0]  mode;
    logic [7:0]  data;
    row_chk_e    chk;
    logic [1:0]  kind;
    logic [1:0]  err;
    logic [15:0] lnum;
  } dir_row_t;

  localparam int DIR_N = 27;
  dir_row_t dir_rows [DIR_N] = '{
    '{MODE_START, 8'h00, CHK_QUIET, KIND_CHAR, ERR_NONE,  16'd0},
    '{MODE_END,   8'h00, CHK_TYPED, KIND_DONE, ERR_NONE,  16'd1},  // empty script
    '{MODE_START, 8'h00, CHK_QUIET, KIND_CHAR, ERR_NONE,  16'd0},
    '{MODE_DATA,  8'hFF, CHK_TYPED, KIND_ERR,  ERR_UTF8,  16'd1},  // illegal lead
    '{MODE_DATA,  8'h78, CHK_QUIET, KIND_CHAR, ERR_NONE,  16'd0},  // ignored after error
    '{MODE_END,   8'h00, CHK_QUIET, KIND_CHAR, ERR_NONE,  16'd0},
    '{MODE_START, 8'hA5, CHK_QUIET, KIND_CHAR, ERR_NONE,  16'd0},
    '{MODE_NONE,  8'h41, CHK_QUIET, KIND_CHAR, ERR_NONE,  16'd0},
    '{MODE_DATA,  8'h09, CHK_PRED,  KIND_CHAR, ERR_NONE,  16'd0},  // leading tab
    '{MODE_DATA,  8'hC3, CHK_PRED,  KIND_CHAR, ERR_NONE,  16'd0},
    '{MODE_DATA,  8'hA9, CHK_PRED,  KIND_CHAR, ERR_NONE,  16'd0},
    '{MODE_DATA,  8'h20, CHK_PRED,  KIND_CHAR, ERR_NONE,  16'd0},  // trailing space
    '{MODE_DATA,  8'h00, CHK_PRED,  KIND_CHAR, ERR_NONE,  16'd0},  // NUL cuts the line
    '{MODE_DATA,  8'h0D, CHK_PRED,  KIND_CHAR, ERR_NONE,  16'd0},
    '{MODE_DATA,  8'h0A, CHK_PRED,  KIND_CHAR, ERR_NONE,  16'd0},  // LF of CR LF
    '{MODE_DATA,  8'h0A, CHK_PRED,  KIND_CHAR, ERR_NONE,  16'd0},  // blank line
    '{MODE_DATA,  8'hED, CHK_PRED,  KIND_CHAR, ERR_NONE,  16'd0},
    '{MODE_DATA,  8'hA0, CHK_PRED,  KIND_CHAR, ERR_NONE,  16'd0},
    '{MODE_DATA,  8'h80, CHK_TYPED, KIND_ERR,  ERR_UTF8,  16'd3},  // surrogate
    '{MODE_START, 8'h00, CHK_QUIET, KIND_CHAR, ERR_NONE,  16'd0},
    '{MODE_DATA,  8'hF0, CHK_PRED,  KIND_CHAR, ERR_NONE,  16'd0},
    '{MODE_DATA,  8'h90, CHK_PRED,  KIND_CHAR, ERR_NONE,  16'd0},
    '{MODE_END,   8'h00, CHK_TYPED, KIND_ERR,  ERR_TRUNC, 16'd1},  // cut sequence
    '{MODE_START, 8'h00, CHK_QUIET, KIND_CHAR, ERR_NONE,  16'd0},
    '{MODE_DATA,  8'hE0, CHK_PRED,  KIND_CHAR, ERR_NONE,  16'd0},
    '{MODE_DATA,  8'h80, CHK_PRED,  KIND_CHAR, ERR_NONE,  16'd0},
    '{MODE_DATA,  8'h80, CHK_TYPED, KIND_ERR,  ERR_UTF8,  16'd1}   // overlong
  };

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic [1:0]  mode_i      = MODE_DATA;
  logic [7:0]  data_byte_i = 8'h00;
  logic        out_ready_i = 1'b0;
  logic        in_ready_o;
  logic        out_valid_o;
  logic [1:0]  kind_o;
  logic [7:0]  char_out_o;
  logic        last_of_line_o;
  logic [1:0]  error_code_o;
  logic [15:0] line_number_o;

  utf8_validating_line_splitter #(
    .LINE_MAX(LINE_MAX)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .mode_i        (mode_i),
    .data_byte_i   (data_byte_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .kind_o        (kind_o),
    .char_out_o    (char_out_o),
    .last_of_line_o(last_of_line_o),
    .error_code_o  (error_code_o),
    .line_number_o (line_number_o)
  );

  always #HALF_PERIOD clk_i = ~clk_i;

  // Splitter state as the block should hold it
  logic [20:0] code_acc;
  logic [16:0] min_cp;
  logic [1:0]  cont_left;
  logic        after_cr;
  logic [6:0]  line_len;
  logic [7:0]  line_buf [LINE_MAX];
  logic [15:0] line_no;
  logic        halted;

  line_word_t  step_out [$];   // words caused by the latest word
  line_word_t  due_words [$];  // words still to come out of the block
  line_word_t  seen_word, due_word;
  int          mismatches = 0;
  int          sent_items = 0;
  logic        gaps_on  = 1'b1;
  logic        hold_req = 1'b0;
  logic        hold_done = 1'b0;
  int          hold_left = 0;

  function automatic line_word_t make_word(logic [1:0] kind, logic [7:0] ch, logic last,
                                           logic [1:0] err);
    return '{kind, ch, last, err, line_no};
  endfunction

  function automatic void clear_script();
    code_acc  = '0;
    min_cp    = '0;
    cont_left = '0;
    after_cr  = 1'b0;
    line_len  = '0;
    foreach (line_buf[i]) line_buf[i] = 8'h00;
    line_no   = 16'd1;
    halted    = 1'b0;
  endfunction

  function automatic void abort_script(logic [1:0] err);
    halted = 1'b1;
    step_out.push_back(make_word(KIND_ERR, 8'h00, 1'b0, err));
  endfunction

  function automatic bit is_blank(logic [7:0] b);
    return b == CHAR_SP || b == CHAR_TAB;
  endfunction

  // Cut at first NUL, strip blanks at both ends, one word per character
  function automatic void flush_line();
    int stop, first;
    stop = 0;
    while (stop < int'(line_len) && line_buf[stop] != CHAR_NUL) stop++;
    first = 0;
    while (first < stop && is_blank(line_buf[first])) first++;
    while (stop > first && is_blank(line_buf[stop-1])) stop--;
    for (int i = first; i < stop; i++)
      step_out.push_back(make_word(KIND_CHAR, line_buf[i], i + 1 == stop, ERR_NONE));
    line_len = '0;
  endfunction

  // 1: character complete, 0: more bytes needed, -1: invalid
  function automatic int decode_byte(logic [7:0] b);
    if (cont_left == 0) begin
      if (b < 8'h80) return 1;
      if (b >= 8'hC2 && b <= 8'hDF) begin
        code_acc = {16'd0, b[4:0]}; min_cp = 17'h80; cont_left = 2'd1;
        return 0;
      end
      if (b >= 8'hE0 && b <= 8'hEF) begin
        code_acc = {17'd0, b[3:0]}; min_cp = 17'h800; cont_left = 2'd2;
        return 0;
      end
      if (b >= 8'hF0 && b <= 8'hF4) begin
        code_acc = {18'd0, b[2:0]}; min_cp = 17'h10000; cont_left = 2'd3;
        return 0;
      end
      return -1;
    end
    if (b[7:6] != 2'b10) return -1;
    code_acc  = {code_acc[14:0], b[5:0]};
    cont_left = cont_left - 2'd1;
    if (cont_left != 0) return 0;
    if (code_acc < {4'd0, min_cp} || (code_acc >= 21'h0D800 && code_acc <= 21'h0DFFF) ||
        code_acc > 21'h10FFFF) return -1;
    return 1;
  endfunction

  function automatic void splitter_step(logic [1:0] m, logic [7:0] b);
    step_out.delete();
    if (m == MODE_START) begin
      clear_script();
      return;
    end
    if (m == MODE_NONE || halted) return;
    if (m == MODE_END) begin
      if (cont_left != 0) begin
        abort_script(ERR_TRUNC);
        return;
      end
      if (line_len != 0) flush_line();
      step_out.push_back(make_word(KIND_DONE, 8'h00, 1'b0, ERR_NONE));
      halted = 1'b1;
      return;
    end
    if (decode_byte(b) < 0) begin
      abort_script(ERR_UTF8);
      return;
    end
    if (b == CHAR_CR || b == CHAR_LF) begin
      if (b == CHAR_LF && after_cr) begin
        after_cr = 1'b0;
        return;
      end
      after_cr = (b == CHAR_CR);
      flush_line();
      if (line_no != 16'hFFFF) line_no = line_no + 16'd1;
      return;
    end
    after_cr = 1'b0;
    if (line_len >= LINE_MAX - 1) begin
      abort_script(ERR_LONG);
      return;
    end
    line_buf[line_len] = b;
    line_len = line_len + 7'd1;
  endfunction

  // Offer one word, wait for the handshake, then update the prediction
  task automatic send_word(input logic [1:0] m, input logic [7:0] b, input bit use_model = 1'b1);
    while (gaps_on && $urandom_range(99) < 24) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    mode_i      <= m;
    data_byte_i <= b;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sent_items++;
    splitter_step(m, b);
    if (use_model) foreach (step_out[j]) due_words.push_back(step_out[j]);
  endtask

  function automatic int utf8_len(logic [20:0] cp);
    if (cp < 21'h80) return 1;
    if (cp < 21'h800) return 2;
    if (cp < 21'h10000) return 3;
    return 4;
  endfunction

  task automatic send_cp(input logic [20:0] cp);
    case (utf8_len(cp))
      1: send_word(MODE_DATA, cp[7:0]);
      2: begin
        send_word(MODE_DATA, {3'b110, cp[10:6]});
        send_word(MODE_DATA, {2'b10, cp[5:0]});
      end
      3: begin
        send_word(MODE_DATA, {4'b1110, cp[15:12]});
        send_word(MODE_DATA, {2'b10, cp[11:6]});
        send_word(MODE_DATA, {2'b10, cp[5:0]});
      end
      default: begin
        send_word(MODE_DATA, {5'b11110, cp[20:18]});
        send_word(MODE_DATA, {2'b10, cp[17:12]});
        send_word(MODE_DATA, {2'b10, cp[11:6]});
        send_word(MODE_DATA, {2'b10, cp[5:0]});
      end
    endcase
  endtask

  function automatic logic [20:0] edge_or_any(logic [20:0] lo, logic [20:0] hi);
    int unsigned r;
    r = $urandom_range(9);
    if (r == 0) return lo;
    if (r == 1) return hi;
    return 21'($urandom_range(int'(lo), int'(hi)));
  endfunction

  function automatic logic [20:0] pick_cp();
    int unsigned r;
    logic [20:0] cp;
    r = $urandom_range(99);
    if (r < 12) cp = $urandom_range(1) ? 21'(CHAR_SP) : 21'(CHAR_TAB);
    else if (r < 15) cp = 21'(CHAR_NUL);
    else if (r < 20) begin
      cp = 21'($urandom_range(1, 31));
      if (cp[7:0] == CHAR_LF || cp[7:0] == CHAR_CR) cp = 21'h7F;
    end else if (r < 50) cp = 21'($urandom_range(8'h21, 8'h7E));
    else if (r < 63) cp = edge_or_any(21'h80, 21'h7FF);
    else if (r < 80) begin
      cp = edge_or_any(21'h800, 21'hFFFF);
      if (cp >= 21'hD800 && cp <= 21'hDFFF) cp = $urandom_range(1) ? 21'hD7FF : 21'hE000;
    end else cp = edge_or_any(21'h10000, 21'h10FFFF);
    return cp;
  endfunction

  task automatic end_line();
    case ($urandom_range(2))
      0: send_word(MODE_DATA, CHAR_CR);
      1: send_word(MODE_DATA, CHAR_LF);
      default: begin
        send_word(MODE_DATA, CHAR_CR);
        send_word(MODE_DATA, CHAR_LF);
      end
    endcase
  endtask

  // Line of exactly nbytes bytes, then a line end
  task automatic send_line(input int nbytes, input bit blanks_only);
    int len, n;
    logic [20:0] cp;
    len = 0;
    while (len < nbytes) begin
      cp = blanks_only ? ($urandom_range(1) ? 21'(CHAR_SP) : 21'(CHAR_TAB)) : pick_cp();
      n = utf8_len(cp);
      if (n > nbytes - len) begin
        cp = 21'h61;
        n  = 1;
      end
      send_cp(cp);
      len += n;
    end
    end_line();
  endtask

  function automatic logic [7:0] any_cont();
    return 8'($urandom_range(8'h80, 8'hBF));
  endfunction

  function automatic logic [7:0] bad_cont();
    case ($urandom_range(3))
      0: return CHAR_CR;
      1: return CHAR_LF;
      2: return 8'($urandom_range(8'h00, 8'h7F));
      default: return 8'($urandom_range(8'hC0, 8'hFF));
    endcase
  endfunction

  // Broken input, always at the start of a line
  task automatic send_flaw();
    logic [7:0] lead;
    case ($urandom_range(8))
      0: send_word(MODE_DATA, $urandom_range(1) ? 8'($urandom_range(8'h80, 8'hC1))
                                                : 8'($urandom_range(8'hF5, 8'hFF)));
      1: begin
        send_word(MODE_DATA, 8'($urandom_range(8'hC2, 8'hF4)));
        send_word(MODE_DATA, bad_cont());
      end
      2: begin  // overlong three-byte form
        send_word(MODE_DATA, 8'hE0);
        send_word(MODE_DATA, 8'($urandom_range(8'h80, 8'h9F)));
        send_word(MODE_DATA, any_cont());
      end
      3: begin  // overlong four-byte form
        send_word(MODE_DATA, 8'hF0);
        send_word(MODE_DATA, 8'($urandom_range(8'h80, 8'h8F)));
        send_word(MODE_DATA, any_cont());
        send_word(MODE_DATA, any_cont());
      end
      4: begin  // surrogate
        send_word(MODE_DATA, 8'hED);
        send_word(MODE_DATA, 8'($urandom_range(8'hA0, 8'hBF)));
        send_word(MODE_DATA, any_cont());
      end
      5: begin  // above 10FFFF
        send_word(MODE_DATA, 8'hF4);
        send_word(MODE_DATA, 8'($urandom_range(8'h90, 8'hBF)));
        send_word(MODE_DATA, any_cont());
        send_word(MODE_DATA, any_cont());
      end
      6: begin  // script ends inside a sequence
        lead = 8'($urandom_range(8'hC2, 8'hF4));
        send_word(MODE_DATA, lead);
        if (lead >= 8'hE0 && $urandom_range(1)) send_word(MODE_DATA, any_cont());
        send_word(MODE_END, 8'($urandom_range(255)));
      end
      7: repeat ($urandom_range(1, 6))
        send_word(2'($urandom_range(3)), 8'($urandom_range(255)));
      default: repeat (LINE_MAX + $urandom_range(3))
        send_word(MODE_DATA, 8'($urandom_range(8'h21, 8'h7E)));
    endcase
    // trailing junk, mostly ignored
    repeat ($urandom_range(2)) send_word(2'($urandom_range(1)), 8'($urandom_range(255)));
  endtask

  task automatic run_script();
    int lines, flaw_at;
    int unsigned r;
    send_word(MODE_START, 8'($urandom_range(255)));
    lines   = $urandom_range(1, 6);
    flaw_at = ($urandom_range(99) < 30) ? int'($urandom_range(lines - 1)) : -1;
    for (int i = 0; i < lines; i++) begin
      if (i == flaw_at) send_flaw();
      r = $urandom_range(99);
      if (r < 6) send_line(LINE_MAX - 1, 1'b0);  // full line
      else if (r < 10) send_line(0, 1'b0);
      else if (r < 14) send_line($urandom_range(1, 4), 1'b1);
      else send_line($urandom_range(1, 12), 1'b0);
    end
    r = $urandom_range(99);
    if (r < 80) send_word(MODE_END, 8'($urandom_range(255)));
    else if (r < 92) begin  // unterminated last line
      repeat ($urandom_range(1, 5)) send_cp(pick_cp());
      send_word(MODE_END, 8'($urandom_range(255)));
    end
  endtask

  // Output side: random back-pressure plus one long hold-off
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      out_ready_i <= 1'b0;
      hold_left   <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      out_ready_i <= 1'b0;
      hold_left   <= HOLD_CYCLES;
      hold_done   <= 1'b1;
    end else begin
      out_ready_i <= !(gaps_on && $urandom_range(99) < 24);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      seen_word = '{kind_o, char_out_o, last_of_line_o, error_code_o, line_number_o};
      if (due_words.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: unexpected word kind=%0d ch=%02h last=%0b err=%0d line=%0d",
                   $time, seen_word.kind, seen_word.ch, seen_word.last, seen_word.err,
                   seen_word.lnum);
      end else begin
        due_word = due_words.pop_front();
        if (seen_word.kind !== due_word.kind || seen_word.ch !== due_word.ch ||
            seen_word.last !== due_word.last || seen_word.err !== due_word.err ||
            seen_word.lnum !== due_word.lnum) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: mismatch exp kind=%0d ch=%02h last=%0b err=%0d line=%0d, got kind=%0d ch=%02h last=%0b err=%0d line=%0d",
                     $time, due_word.kind, due_word.ch, due_word.last, due_word.err,
                     due_word.lnum, seen_word.kind, seen_word.ch, seen_word.last,
                     seen_word.err, seen_word.lnum);
        end
      end
    end
  end

  initial begin
    int n_script;
    clear_script();
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < DIR_N; i++) begin
      send_word(dir_rows[i].mode, dir_rows[i].data, dir_rows[i].chk == CHK_PRED);
      if (dir_rows[i].chk == CHK_TYPED)
        due_words.push_back('{dir_rows[i].kind, 8'h00, 1'b0, dir_rows[i].err,
                              dir_rows[i].lnum});
    end

    // Output stalls for a long stretch while scripts keep coming
    hold_req <= 1'b1;
    n_script = 0;
    while (sent_items < ITEM_TARGET) begin
      // scripts 1 and 2 run with no idling on either side
      gaps_on <= !(n_script == 1 || n_script == 2);
      run_script();
      n_script++;
    end
    in_valid_i <= 1'b0;

    while (due_words.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && due_words.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// File: utf8_validating_line_splitter.f
hw/rtl/u8ls_pkg.sv
hw/rtl/u8ls_ram.sv
hw/rtl/u8ls_fifo.sv
hw/rtl/u8ls_front.sv
hw/rtl/u8ls_back.sv
hw/rtl/utf8_validating_line_splitter.sv
hw/rtl/u8ls_checker.sv
dv/tb_utf8_validating_line_splitter.sv
